// File: design/bpmw_pkg.sv
// Shared types and constants for the block pair mean watermark engine.
// No dependencies.
`default_nettype none
package bpmw_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;

  localparam logic [7:0] MarkThreshold = 8'd10;

  // input item commands (s_tuser)
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_CELL    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BLOCK_W  = 3'd0,
    REG_BLOCK_H  = 3'd1,
    REG_IMAGE_W  = 3'd2,
    REG_IMAGE_H  = 3'd3,
    REG_MODE     = 3'd4
  } reg_e;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

endpackage
`default_nettype wire

// File: design/block_pair_mean_watermark.sv
// Top level of the block pair mean watermark engine: pixel store, cell
// sequencer with one shared accumulate/divide unit. Depends on bpmw_pkg.
//
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+-----------------------------------
// s_axis   | in  | s_tvalid/s_tready    | tuser command, tdata pixel+mark
// m_axis   | out | m_tvalid/m_tready    | tdata pixel bytes, cell, flags
// cfg      | in  | cfg_valid/cfg_ready  | cfg_index_i, cfg_data_i
//
// A cell makes one store read per pixel, then two 24-step divisions in
// the shared divider; when a hide swaps the pair, each pixel then takes
// read A, read B, write A, write B (one read and one write store port).
// Reset clears control state and cursor; the store is undefined until
// written. The input is not ready until the result is in the output
// register; a stalled output holds while the next item is worked on.
`default_nettype none
module block_pair_mean_watermark
  import bpmw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // tdata: pixel_x[7:0], pixel_y[15:8], blue_in[23:16], green_in[31:24],
  //        red_in[39:32], mark_value[47:40]
  input  wire logic [InDataW-1:0]  s_tdata,
  // tuser: command[1:0]
  input  wire logic [1:0]          s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // tdata: blue_out[7:0], green_out[15:8], red_out[23:16],
  //        cell_value[31:24], swapped[32], status[33], zeros above
  output logic [OutDataW-1:0]      m_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [8:0]          cfg_data_i
);

  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned IwMax  = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
  localparam int unsigned IhMax  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_RD_WAIT, ST_SUM, ST_SUM_TAIL, ST_DIV, ST_SWAP,
    ST_FINISH
  } state_e;

  // configuration
  logic [7:0] bw_cfg_q;
  logic [8:0] bh_cfg_q, iw_cfg_q, ih_cfg_q;
  logic       mode_q;

  assign cfg_ready_o = 1'b1;

  // clamped configuration
  logic [7:0] bw;
  logic [8:0] bh, iw, ih;
  always_comb begin
    bw = (bw_cfg_q == 8'd0) ? 8'd1 : ((bw_cfg_q > 8'd128) ? 8'd128 : bw_cfg_q);
    bh = (bh_cfg_q == 9'd0) ? 9'd1 : ((bh_cfg_q > 9'd256) ? 9'd256 : bh_cfg_q);
    iw = (iw_cfg_q < 9'd2) ? 9'd2 : iw_cfg_q;
    if (32'(iw) > IwMax) iw = 9'(IwMax);
    ih = (ih_cfg_q < 9'd1) ? 9'd1 : ih_cfg_q;
    if (32'(ih) > IhMax) ih = 9'(IhMax);
  end

  state_e       state_q;
  logic [1:0]   cmd_q;
  logic [7:0]   px_q, py_q, mark_q;
  logic [23:0]  wpix_q;
  logic [8:0]   cur_col_q, cur_row_q;
  logic [8:0]   col_base_q, row_base_q;
  logic [7:0]   xc_q, yc_q;
  logic [1:0]   phase_q;
  logic         pend_q, pend_right_q;
  logic [23:0]  sum_l_q, sum_r_q;
  logic [15:0]  count_q;
  logic [15:0]  rem_q;
  logic [23:0]  quo_q;
  logic [4:0]   div_cnt_q;
  logic         div_right_q;
  logic [7:0]   mean_l_q;
  logic [23:0]  tmp_q;
  logic [23:0]  res_pix_q;
  logic [7:0]   res_cell_q;
  logic         res_swap_q, res_status_q;
  logic [OutDataW-1:0] m_data_q;
  logic         m_valid_q;

  assign s_tready = (state_q == ST_IDLE);
  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;

  // pixel store, one write and one registered read port
  logic [23:0]   mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [23:0]   mem_wdata;
  logic [23:0]   rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[mem_raddr];
  end

  function automatic logic [AW-1:0] pix_addr(input logic [8:0] x, input logic [8:0] y);
    pix_addr = AW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
  endfunction

  logic in_store;
  assign in_store = (32'(px_q) < MAX_WIDTH) && (32'(py_q) < MAX_HEIGHT);

  // cell coordinates of the current pixel
  logic [8:0] cx, cy, cx_b;
  always_comb begin
    cx   = col_base_q + {1'b0, xc_q};
    cy   = row_base_q + {1'b0, yc_q};
    cx_b = cx + {1'b0, bw};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr(cx, cy);
    mem_wdata = rd_data_q;
    mem_raddr = pix_addr(cx, cy);
    case (state_q)
      ST_EXEC: begin
        mem_raddr = pix_addr({1'b0, px_q}, {1'b0, py_q});
        mem_waddr = pix_addr({1'b0, px_q}, {1'b0, py_q});
        mem_wdata = wpix_q;
        mem_we    = (cmd_q == CMD_WRITE) && in_store;
      end
      ST_SWAP: begin
        if (phase_q == 2'd1) mem_raddr = pix_addr(cx_b, cy);
        if (phase_q == 2'd2) mem_we = 1'b1;
        if (phase_q == 2'd3) begin
          mem_we    = 1'b1;
          mem_waddr = pix_addr(cx_b, cy);
          mem_wdata = tmp_q;
        end
      end
      default: ;
    endcase
  end

  // cursor step for a cell command
  logic [9:0] need, col_n, row_n;
  logic [9:0] bw2;
  logic       no_room;
  always_comb begin
    bw2   = {1'b0, bw, 1'b0};
    col_n = {1'b0, cur_col_q};
    row_n = {1'b0, cur_row_q};
    need  = col_n + bw2;
    if (need > {1'b0, iw}) begin
      row_n = row_n + {1'b0, bh};
      col_n = 10'd0;
    end
    no_room = (col_n + bw2 > {1'b0, iw}) || (row_n + {1'b0, bh} > {1'b0, ih});
  end

  // shared divider step
  logic [16:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {rem_q, quo_q[23]};
  assign div_ge = rem_sh >= {1'b0, count_q};

  logic [7:0] mean_r;
  assign mean_r = div_ge ? {quo_q[6:0], 1'b1} : {quo_q[6:0], 1'b0};

  logic       x_last_sum, y_last, x_last_sw;
  assign x_last_sum = ({1'b0, xc_q} == {bw, 1'b0} - 9'd1);
  assign x_last_sw  = (xc_q == bw - 8'd1);
  assign y_last     = ({1'b0, yc_q} == bh - 9'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bw_cfg_q   <= 8'd8;
      bh_cfg_q   <= 9'd8;
      iw_cfg_q   <= 9'd256;
      ih_cfg_q   <= 9'd256;
      mode_q     <= 1'b0;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      pend_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_BLOCK_W: bw_cfg_q <= cfg_data_i[7:0];
          REG_BLOCK_H: bh_cfg_q <= cfg_data_i;
          REG_IMAGE_W: iw_cfg_q <= cfg_data_i;
          REG_IMAGE_H: ih_cfg_q <= cfg_data_i;
          REG_MODE:    mode_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_valid_q && m_tready) m_valid_q <= 1'b0;

      // accumulate the store read issued last cycle
      pend_q <= 1'b0;
      if (pend_q) begin
        if (pend_right_q) sum_r_q <= sum_r_q + {16'd0, rd_data_q[7:0]};
        else              sum_l_q <= sum_l_q + {16'd0, rd_data_q[7:0]};
      end

      case (state_q)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q   <= s_tuser;
            px_q    <= s_tdata[7:0];
            py_q    <= s_tdata[15:8];
            wpix_q  <= s_tdata[39:16];
            mark_q  <= s_tdata[47:40];
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_pix_q    <= '0;
          res_cell_q   <= '0;
          res_swap_q   <= 1'b0;
          res_status_q <= 1'b0;
          state_q      <= ST_FINISH;
          case (cmd_q)
            CMD_READ:    state_q <= ST_RD_WAIT;
            CMD_RESTART: begin
              cur_col_q <= '0;
              cur_row_q <= '0;
            end
            CMD_CELL: begin
              if (no_room) begin
                res_status_q <= 1'b1;
              end else begin
                col_base_q <= col_n[8:0];
                row_base_q <= row_n[8:0];
                xc_q       <= '0;
                yc_q       <= '0;
                sum_l_q    <= '0;
                sum_r_q    <= '0;
                count_q    <= 16'({8'd0, bw} * {7'd0, bh});
                state_q    <= ST_SUM;
              end
            end
            default: ;
          endcase
        end
        ST_RD_WAIT: begin
          if (in_store) res_pix_q <= rd_data_q;
          state_q <= ST_FINISH;
        end
        ST_SUM: begin
          pend_q       <= 1'b1;
          pend_right_q <= (xc_q >= bw);
          if (x_last_sum) begin
            xc_q <= '0;
            yc_q <= yc_q + 8'd1;
            if (y_last) state_q <= ST_SUM_TAIL;
          end else begin
            xc_q <= xc_q + 8'd1;
          end
        end
        ST_SUM_TAIL: begin
          // last sample lands this cycle
          state_q <= ST_DIV;
          div_right_q <= 1'b0;
          div_cnt_q   <= '0;
          rem_q       <= '0;
          quo_q       <= pend_right_q ? sum_l_q : sum_l_q;
        end
        ST_DIV: begin
          rem_q     <= div_ge ? 16'(rem_sh - {1'b0, count_q}) : rem_sh[15:0];
          quo_q     <= {quo_q[22:0], div_ge};
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'd23) begin
            div_cnt_q <= '0;
            rem_q     <= '0;
            if (!div_right_q) begin
              mean_l_q    <= mean_r;
              div_right_q <= 1'b1;
              quo_q       <= sum_r_q;
            end else begin
              cur_col_q <= 9'(col_base_q + {bw, 1'b0});
              cur_row_q <= row_base_q;
              xc_q      <= '0;
              yc_q      <= '0;
              phase_q   <= 2'd0;
              state_q   <= ST_FINISH;
              if (mode_q) begin
                res_cell_q <= (mean_l_q > mean_r) ? 8'd0 : 8'd255;
              end else if ((mean_l_q > mean_r && mark_q > MarkThreshold) ||
                           (mean_l_q < mean_r && mark_q < MarkThreshold)) begin
                res_swap_q <= 1'b1;
                state_q    <= ST_SWAP;
              end
            end
          end
        end
        ST_SWAP: begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd1) tmp_q <= rd_data_q;
          if (phase_q == 2'd3) begin
            if (x_last_sw) begin
              xc_q <= '0;
              yc_q <= yc_q + 8'd1;
              if (y_last) state_q <= ST_FINISH;
            end else begin
              xc_q <= xc_q + 8'd1;
            end
          end
        end
        ST_FINISH: begin
          if (!m_valid_q || m_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {6'd0, res_status_q, res_swap_q, res_cell_q,
                          res_pix_q[23:16], res_pix_q[15:8], res_pix_q[7:0]};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/bpmw_checker.sv
// Port-level checker for block_pair_mean_watermark, with its bind.
// Depends on bpmw_pkg.
`default_nettype none
module bpmw_checker
  import bpmw_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [OutDataW-1:0] m_tdata
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // no room means nothing else reported
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[33] |-> m_tdata[32:0] == 33'd0)
    else $error("status with payload");

  // swap and extracted cell exclude each other
  a_swap_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0)
    else $error("swap with other payload");

endmodule

bind block_pair_mean_watermark bpmw_checker u_bpmw_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
